// File: sv/rds_pkg.sv
// Shared types and constants for the random distribution shaper.
`default_nettype none

package rds_pkg;

   localparam int UNIFORM_BITS_DEFAULT = 32;

   localparam logic [30:0] LN2_Q31     = 31'd1488522236;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;
   localparam logic [31:0] DIV3_RECIP  = 32'h5555_5555;

   localparam int HORNER_STEPS = 6;

   localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{
      8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
   };
   localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
      32'd32537631, 32'd47721858, 32'd76695844,
      32'd143165576, 32'd357913941, 32'd2147483648
   };
   localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{
      8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
   };
   localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
      32'd27531841, 32'd39045157, 32'd59652323,
      32'd102261126, 32'd214748364, 32'd715827882
   };

   typedef enum logic [1:0] {
      DIST_UNIFORM,
      DIST_NORMAL,
      DIST_TRIANGULAR,
      DIST_EXPONENTIAL
   } dist_type;

   typedef enum logic [1:0] {
      REG_LOWER,
      REG_UPPER,
      REG_DIST,
      REG_SUCCESS
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] first_uniform;
      logic [31:0] second_uniform;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               success_out;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/random_distribution_shaper.sv
// Top level of the random distribution shaper: pipelined sample shaping.
// Throughput: one item per cycle while the skid stage is empty; depth is set by the 28-stage log
// squaring chain and the 32-stage square root, one result bit or log bit per stage.
// A one-entry skid stage takes an item during an output stall; req_stall is its valid bit.
// Reset (synchronous) clears all valid bits and loads register reset values.
`default_nettype none

module random_distribution_shaper #(
   parameter int UNIFORM_BITS = rds_pkg::UNIFORM_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rds_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rds_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int          DROP = (UNIFORM_BITS >= 32) ? 0 : 32 - UNIFORM_BITS;
   localparam logic [31:0] DRAW_MASK = 32'hFFFF_FFFF << DROP;
   localparam logic [32:0] TWO32 = 33'h1_0000_0000;

   localparam int ST_PREP    = 1;
   localparam int ST_LZ      = 2;
   localparam int ST_NORM    = 3;
   localparam int ST_HORNER  = 3;
   localparam int ST_SINMUL  = ST_HORNER + 3 * rds_pkg::HORNER_STEPS;
   localparam int ST_MAG     = ST_SINMUL + 1;
   localparam int ST_LOG     = 4;
   localparam int LOG_ITER   = 28;
   localparam int ST_TL      = ST_LOG + LOG_ITER;
   localparam int ST_LN      = ST_TL + 1;
   localparam int ST_SQLOAD  = ST_LN + 1;
   localparam int ST_SQRT    = ST_SQLOAD + 1;
   localparam int SQRT_ITER  = 32;
   localparam int ST_MAGMUL  = ST_SQRT + SQRT_ITER;
   localparam int ST_SPANMUL = ST_MAGMUL + 1;
   localparam int ST_DIV     = ST_SPANMUL + 1;
   localparam int ST_FIX     = ST_DIV + 1;
   localparam int ST_OUT     = ST_FIX + 1;
   localparam int LAST       = ST_OUT;

   typedef struct packed {
      logic [31:0]        u1;
      logic [31:0]        u2;
      logic [1:0]         quad;
      logic               tri_hi;
      logic [32:0]        v;
      logic               zlog;
      logic [4:0]         p;
      logic [31:0]        y;
      logic [27:0]        frac;
      logic [33:0]        tl;
      logic [33:0]        w;
      logic [30:0]        x;
      logic [31:0]        x2;
      logic [30:0]        hc;
      logic [30:0]        hs;
      logic [61:0]        hc_prod;
      logic [61:0]        hs_prod;
      logic [31:0]        hc_num;
      logic [31:0]        hs_num;
      logic [31:0]        hc_qe;
      logic [31:0]        hs_qe;
      logic [30:0]        mag;
      logic               neg;
      logic [63:0]        sqn;
      logic [63:0]        sqr;
      logic               lbig;
      logic [63:0]        prod;
      logic [31:0]        m;
      logic [33:0]        num;
      logic [32:0]        qe;
      logic [33:0]        off;
      logic signed [31:0] value;
   } item_type;

   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [32:0] log_step(input logic [31:0] y);
      logic [63:0] sq;
      logic [32:0] t;
      sq = 64'(y) * 64'(y);
      t  = sq[63:31];
      return t[32] ? {1'b1, t[32:1]} : {1'b0, t[31:0]};
   endfunction

   function automatic logic [31:0] recip_est(input logic [31:0] num, input logic [31:0] r);
      logic [63:0] pr;
      pr = 64'(num) * 64'(r);
      return pr[63:32];
   endfunction

   function automatic logic [30:0] horner_fix(input logic [31:0] num, input logic [31:0] qe,
                                              input logic [7:0] k);
      logic [39:0] rem;
      logic [32:0] p;
      rem = 40'(num) - 40'(qe) * 40'(k);
      p   = 33'(qe) + ((rem >= 40'(k)) ? 33'd1 : 33'd0);
      return (p >= 33'(rds_pkg::ONE_Q30)) ? 31'd0 : 31'(33'(rds_pkg::ONE_Q30) - p);
   endfunction

   logic [31:0]       lower_ff;
   logic [31:0]       upper_ff;
   rds_pkg::dist_type dist_ff;
   logic              success_ff;

   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic [31:0]        span_ff, span_in;
   logic signed [31:0] mid_ff, mid_in;

   item_type         st_ff [0:LAST];
   item_type         st_in [0:LAST];
   logic [LAST:0]    vld_ff;
   logic             adv;

   logic             rsp_vld_ff;
   rds_pkg::rsp_type rsp_data_ff;
   logic             skid_vld_ff;
   rds_pkg::rsp_type skid_data_ff;
   logic             out_free;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= '0;
         upper_ff   <= 32'd65536;
         dist_ff    <= rds_pkg::DIST_UNIFORM;
         success_ff <= 1'b1;
      end else if (cfg_wr) begin
         unique case (rds_pkg::reg_idx_type'(paddr[3:2]))
            rds_pkg::REG_LOWER:   lower_ff   <= pwdata;
            rds_pkg::REG_UPPER:   upper_ff   <= pwdata;
            rds_pkg::REG_DIST:    dist_ff    <= rds_pkg::dist_type'(pwdata[1:0]);
            rds_pkg::REG_SUCCESS: success_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (rds_pkg::reg_idx_type'(paddr[3:2]))
         rds_pkg::REG_LOWER:   prdata = lower_ff;
         rds_pkg::REG_UPPER:   prdata = upper_ff;
         rds_pkg::REG_DIST:    prdata = {30'd0, dist_ff};
         rds_pkg::REG_SUCCESS: prdata = {31'd0, success_ff};
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      if ($signed(lower_ff) > $signed(upper_ff)) begin
         lo_in = $signed(upper_ff);
         hi_in = $signed(lower_ff);
      end else begin
         lo_in = $signed(lower_ff);
         hi_in = $signed(upper_ff);
      end
      span_in = 32'(hi_in - lo_in);
      mid_in  = lo_ff + $signed({1'b0, span_ff[31:1]});
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      span_ff <= span_in;
      mid_ff  <= mid_in;
   end

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_comb begin
      st_in[0]    = '0;
      st_in[0].u1 = req_data.first_uniform & DRAW_MASK;
      st_in[0].u2 = req_data.second_uniform & DRAW_MASK;
   end

   for (genvar g = 1; g <= LAST; g++) begin : g_stage
      localparam int HOFF   = (g >= ST_HORNER) ? (g - ST_HORNER) : 0;
      localparam int HK_RAW = HOFF / 3;
      localparam int HK     = (HK_RAW > rds_pkg::HORNER_STEPS - 1) ?
                              rds_pkg::HORNER_STEPS - 1 : HK_RAW;
      localparam int HP     = HOFF % 3;
      localparam int SJ     = (g >= ST_SQRT && g < ST_SQRT + SQRT_ITER) ? (g - ST_SQRT) : 0;
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * SJ);

      always_comb begin : p_stage
         logic [63:0]        mul64;
         logic [65:0]        mul66;
         logic [32:0]        lstep;
         logic [35:0]        rem;
         logic [63:0]        sq_sum;
         logic signed [35:0] cand;
         logic signed [35:0] lo36;
         logic signed [35:0] hi36;
         logic signed [35:0] mid36;
         logic signed [35:0] off36;

         mul64  = '0;
         mul66  = '0;
         lstep  = '0;
         rem    = '0;
         sq_sum = '0;
         cand   = '0;
         lo36   = 36'(lo_ff);
         hi36   = 36'(hi_ff);
         mid36  = 36'(mid_ff);
         off36  = $signed({2'b00, st_ff[g-1].off});
         st_in[g] = st_ff[g-1];

         if (g == ST_PREP) begin
            if (dist_ff == rds_pkg::DIST_EXPONENTIAL) begin
               st_in[g].v = TWO32 - 33'(st_ff[g-1].u1);
            end else begin
               st_in[g].v = (st_ff[g-1].u1 == '0) ? 33'd1 : 33'(st_ff[g-1].u1);
            end
            mul64 = 64'(st_ff[g-1].u2[29:0]) * 64'(rds_pkg::HALF_PI_Q30);
            st_in[g].x      = mul64[60:30];
            st_in[g].quad   = st_ff[g-1].u2[31:30];
            st_in[g].tri_hi = st_ff[g-1].u1[31];
            st_in[g].prod   = 64'(st_ff[g-1].u1) * 64'(span_ff);
            if (st_ff[g-1].u1[31]) begin
               st_in[g].sqn = 64'(TWO32 - 33'(st_ff[g-1].u1)) << 31;
            end else begin
               st_in[g].sqn = 64'(st_ff[g-1].u1) << 31;
            end
            st_in[g].hc = rds_pkg::ONE_Q30;
            st_in[g].hs = rds_pkg::ONE_Q30;
         end

         if (g == ST_LZ) begin
            st_in[g].p    = lead_one(st_ff[g-1].v[31:0]);
            st_in[g].zlog = st_ff[g-1].v[32];
            mul64 = 64'(st_ff[g-1].x) * 64'(st_ff[g-1].x);
            st_in[g].x2 = mul64[61:30];
         end

         if (g == ST_NORM) begin
            st_in[g].y    = st_ff[g-1].v[31:0] << (5'd31 - st_ff[g-1].p);
            st_in[g].frac = '0;
         end

         if (g >= ST_HORNER && g < ST_SINMUL) begin
            if (HP == 0) begin
               st_in[g].hc_prod = 62'(st_ff[g-1].x2) * 62'(st_ff[g-1].hc);
               st_in[g].hs_prod = 62'(st_ff[g-1].x2) * 62'(st_ff[g-1].hs);
            end else if (HP == 1) begin
               st_in[g].hc_num = st_ff[g-1].hc_prod[61:30];
               st_in[g].hs_num = st_ff[g-1].hs_prod[61:30];
               st_in[g].hc_qe  = recip_est(st_ff[g-1].hc_prod[61:30],
                                           rds_pkg::COS_RECIP[HK]);
               st_in[g].hs_qe  = recip_est(st_ff[g-1].hs_prod[61:30],
                                           rds_pkg::SIN_RECIP[HK]);
            end else begin
               st_in[g].hc = horner_fix(st_ff[g-1].hc_num, st_ff[g-1].hc_qe,
                                        rds_pkg::COS_DIV[HK]);
               st_in[g].hs = horner_fix(st_ff[g-1].hs_num, st_ff[g-1].hs_qe,
                                        rds_pkg::SIN_DIV[HK]);
            end
         end

         if (g == ST_SINMUL) begin
            mul64 = 64'(st_ff[g-1].x) * 64'(st_ff[g-1].hs);
            st_in[g].hs = mul64[60:30];
         end

         if (g == ST_MAG) begin
            st_in[g].mag = (st_ff[g-1].quad == 2'd0 || st_ff[g-1].quad == 2'd2) ?
                           st_ff[g-1].hc : st_ff[g-1].hs;
            st_in[g].neg = (st_ff[g-1].quad == 2'd1 || st_ff[g-1].quad == 2'd2);
         end

         if (g >= ST_LOG && g < ST_TL) begin
            lstep = log_step(st_ff[g-1].y);
            st_in[g].y    = lstep[31:0];
            st_in[g].frac = {st_ff[g-1].frac[26:0], lstep[32]};
         end

         if (g == ST_TL) begin
            if (st_ff[g-1].zlog) begin
               st_in[g].tl = '0;
            end else begin
               st_in[g].tl = (34'(6'd32 - 6'(st_ff[g-1].p)) << 28) - 34'(st_ff[g-1].frac);
            end
         end

         if (g == ST_LN) begin
            mul66 = 66'(st_ff[g-1].tl) * 66'(rds_pkg::LN2_Q31);
            st_in[g].w = mul66[63:30];
         end

         if (g == ST_SQLOAD) begin
            if (dist_ff != rds_pkg::DIST_TRIANGULAR) begin
               st_in[g].sqn = 64'(st_ff[g-1].w) << 28;
            end
            st_in[g].sqr  = '0;
            st_in[g].lbig = st_ff[g-1].w[33:1] >= 33'(32'd3 << 28);
            if (dist_ff == rds_pkg::DIST_EXPONENTIAL) begin
               st_in[g].prod = 64'(st_ff[g-1].w[30:1]) * 64'(span_ff);
            end
         end

         if (g >= ST_SQRT && g < ST_MAGMUL) begin
            sq_sum = st_ff[g-1].sqr + SQ_BIT;
            if (st_ff[g-1].sqn >= sq_sum) begin
               st_in[g].sqn = st_ff[g-1].sqn - sq_sum;
               st_in[g].sqr = (st_ff[g-1].sqr >> 1) + SQ_BIT;
            end else begin
               st_in[g].sqr = st_ff[g-1].sqr >> 1;
            end
         end

         if (g == ST_MAGMUL) begin
            if (dist_ff == rds_pkg::DIST_NORMAL) begin
               mul64 = 64'(st_ff[g-1].sqr[31:0]) * 64'(st_ff[g-1].mag);
               st_in[g].m = mul64[61:30];
            end else if (dist_ff == rds_pkg::DIST_TRIANGULAR) begin
               st_in[g].prod = 64'(st_ff[g-1].sqr[31:0]) * 64'(span_ff);
            end
         end

         if (g == ST_SPANMUL) begin
            if (dist_ff == rds_pkg::DIST_NORMAL) begin
               st_in[g].prod = 64'(st_ff[g-1].m) * 64'(span_ff);
            end
         end

         if (g == ST_DIV) begin
            priority case (dist_ff)
               rds_pkg::DIST_NORMAL:      st_in[g].num = st_ff[g-1].prod[62:29];
               rds_pkg::DIST_EXPONENTIAL: st_in[g].num = st_ff[g-1].prod[61:28];
               default:                   st_in[g].num = {2'b00, st_ff[g-1].prod[63:32]};
            endcase
            mul66 = 66'(st_in[g].num) * 66'(rds_pkg::DIV3_RECIP);
            st_in[g].qe = mul66[64:32];
         end

         if (g == ST_FIX) begin
            if (dist_ff == rds_pkg::DIST_NORMAL || dist_ff == rds_pkg::DIST_EXPONENTIAL) begin
               rem = 36'(st_ff[g-1].num) - 36'(st_ff[g-1].qe) * 36'd3;
               if (rem >= 36'd6) begin
                  st_in[g].off = 34'(st_ff[g-1].qe) + 34'd2;
               end else if (rem >= 36'd3) begin
                  st_in[g].off = 34'(st_ff[g-1].qe) + 34'd1;
               end else begin
                  st_in[g].off = 34'(st_ff[g-1].qe);
               end
            end else begin
               st_in[g].off = st_ff[g-1].num;
            end
         end

         if (g == ST_OUT) begin
            unique case (dist_ff)
               rds_pkg::DIST_UNIFORM:     cand = lo36 + off36;
               rds_pkg::DIST_NORMAL:      cand = st_ff[g-1].neg ? mid36 - off36 : mid36 + off36;
               rds_pkg::DIST_TRIANGULAR:  cand = st_ff[g-1].tri_hi ? hi36 - off36 : lo36 + off36;
               rds_pkg::DIST_EXPONENTIAL: cand = lo36 + off36;
               default:                   cand = lo36;
            endcase
            if (cand < lo36) begin
               cand = lo36;
            end else if (cand > hi36) begin
               cand = hi36;
            end
            if (dist_ff == rds_pkg::DIST_EXPONENTIAL && st_ff[g-1].lbig) begin
               cand = hi36;
            end
            if (span_ff == '0) begin
               cand = lo36;
            end
            st_in[g].value = 32'(cand);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= LAST; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_free = !rsp_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_vld_ff <= vld_ff[LAST];
         end
      end else if (vld_ff[LAST] && !skid_vld_ff) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_vld_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else begin
            rsp_data_ff <= {st_ff[LAST].value, success_ff};
         end
      end else if (!skid_vld_ff) begin
         skid_data_ff <= {st_ff[LAST].value, success_ff};
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall && !skid_vld_ff && vld_ff[LAST]) |=> skid_vld_ff)
      else $error("finished item not caught by the skid stage");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_data_ff.sample_value >= lo_ff && rsp_data_ff.sample_value <= hi_ff))
      else $error("sample outside the configured range");

endmodule

`default_nettype wire

// File: bench/random_distribution_shaper_tb.sv
// Testbench for the random distribution shaper: predicted samples checked against the block.
module random_distribution_shaper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   rds_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   rds_pkg::rsp_type rsp_data;
   logic             psel = 0, penable = 0, pwrite = 0;
   logic [3:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   random_distribution_shaper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   logic [31:0]       lower_reg, upper_reg;
   rds_pkg::dist_type dist_reg;
   logic              success_reg;

   rds_pkg::req_type pending_items[$];
   rds_pkg::rsp_type expected_samples[$];
   int      error_count = 0;
   int      sent_count = 0, checked_count = 0;
   int      idle_cycles = 0;
   int      send_gap = 0, stall_gap = 0;
   bit      hold_sender = 0;

   function automatic int gap_length();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bit_q;
      res = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > n) bit_q = bit_q >> 2;
      while (bit_q != 0) begin
         if (n >= res + bit_q) begin
            n = n - (res + bit_q);
            res = (res >> 1) + bit_q;
         end else begin
            res = res >> 1;
         end
         bit_q = bit_q >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] neglog2_q28(logic [63:0] v);
      int p;
      logic [63:0] y, frac;
      frac = 0;
      p = 0;
      if (v == 0) v = 1;
      if (v >= 64'h1_0000_0000) return 0;
      while ((v >> (p + 1)) != 0) p++;
      y = v << (31 - p);
      for (int i = 0; i < 28; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(32 - p) << 28) - frac;
   endfunction

   function automatic logic [63:0] taylor_term(logic [63:0] x2, logic [63:0] inner,
                                                logic [63:0] k);
      logic [63:0] pr;
      pr = ((x2 * inner) >> 30) / k;
      return (pr >= 64'(rds_pkg::ONE_Q30)) ? 64'd0 : 64'(rds_pkg::ONE_Q30) - pr;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rds_pkg::rsp_type shape_sample(rds_pkg::req_type item);
      longint           lo, hi, v, mid, t;
      logic [63:0]      span, u1, u2, w, r, x, x2, c, s, mag, m, off, l, sq;
      logic [1:0]       q;
      rds_pkg::rsp_type res;
      u1 = item.first_uniform;
      u2 = item.second_uniform;
      lo = longint'($signed(lower_reg));
      hi = longint'($signed(upper_reg));
      if (lo > hi) begin
         t = lo; lo = hi; hi = t;
      end
      span = 64'(hi - lo);
      if (span == 0) begin
         v = lo;
      end else if (dist_reg == rds_pkg::DIST_NORMAL) begin
         mid = lo + longint'(span >> 1);
         if (u1 == 0) u1 = 1;
         w = (neglog2_q28(u1) * 64'(rds_pkg::LN2_Q31)) >> 30;
         r = root64(w << 28);
         x = ((u2 & 64'h3FFF_FFFF) * 64'(rds_pkg::HALF_PI_Q30)) >> 30;
         x2 = (x * x) >> 30;
         c = 64'(rds_pkg::ONE_Q30);
         s = 64'(rds_pkg::ONE_Q30);
         for (int i = 0; i < rds_pkg::HORNER_STEPS; i++) begin
            c = taylor_term(x2, c, 64'(rds_pkg::COS_DIV[i]));
            s = taylor_term(x2, s, 64'(rds_pkg::SIN_DIV[i]));
         end
         s = (x * s) >> 30;
         q = u2[31:30];
         mag = (q == 0 || q == 2) ? c : s;
         m = (r * mag) >> 30;
         off = (m * span) / (64'd6 << 28);
         v = clip((q == 1 || q == 2) ? mid - longint'(off) : mid + longint'(off), lo, hi);
      end else if (dist_reg == rds_pkg::DIST_TRIANGULAR) begin
         if (u1 < 64'h8000_0000) begin
            sq = root64(u1 << 31);
            v = clip(lo + longint'((sq * span) >> 32), lo, hi);
         end else begin
            sq = root64((64'h1_0000_0000 - u1) << 31);
            v = clip(hi - longint'((sq * span) >> 32), lo, hi);
         end
      end else if (dist_reg == rds_pkg::DIST_EXPONENTIAL) begin
         l = (neglog2_q28(64'h1_0000_0000 - u1) * 64'(rds_pkg::LN2_Q31)) >> 31;
         if (l >= (64'd3 << 28)) v = hi;
         else v = clip(lo + longint'((l * span) / (64'd3 << 28)), lo, hi);
      end else begin
         v = lo + longint'((u1 * span) >> 32);
      end
      res.sample_value = v[31:0];
      res.success_out = success_reg;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at result %0d: got %h, want %h", what, checked_count, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_samples.push_back(shape_sample(req_data));
            sent_count++;
         end
         if (req_valid && req_stall) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (!hold_sender && pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1;
            send_gap <= gap_length();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected item", rsp_data.sample_value, 32'd0);
            end else begin
               rds_pkg::rsp_type want;
               want = expected_samples.pop_front();
               if (rsp_data.sample_value !== want.sample_value)
                  report_mismatch("sample_value", rsp_data.sample_value, want.sample_value);
               if (rsp_data.success_out !== want.success_out)
                  report_mismatch("success_out", 32'(rsp_data.success_out),
                                  32'(want.success_out));
            end
            checked_count++;
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            stall_gap <= gap_length();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_samples.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(rds_pkg::reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= 4'(idx) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      unique case (idx)
         rds_pkg::REG_LOWER:   lower_reg = value;
         rds_pkg::REG_UPPER:   upper_reg = value;
         rds_pkg::REG_DIST:    dist_reg = rds_pkg::dist_type'(value[1:0]);
         rds_pkg::REG_SUCCESS: success_reg = value[0];
      endcase
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_samples.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_item(logic [31:0] a, logic [31:0] b);
      rds_pkg::req_type it;
      it.first_uniform = a;
      it.second_uniform = b;
      pending_items.push_back(it);
   endtask

   task automatic configure(logic [31:0] lo, logic [31:0] hi, rds_pkg::dist_type d,
                            logic succ);
      write_reg(rds_pkg::REG_LOWER, lo);
      write_reg(rds_pkg::REG_UPPER, hi);
      write_reg(rds_pkg::REG_DIST, 32'(d));
      write_reg(rds_pkg::REG_SUCCESS, 32'(succ));
   endtask

   logic [31:0] bound_lo, bound_hi;

   initial begin
      lower_reg = 0;
      upper_reg = 32'd65536;
      dist_reg = rds_pkg::DIST_UNIFORM;
      success_reg = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      for (int d = 0; d < 4; d++) begin
         for (int r = 0; r < 4; r++) begin
            case (r)
               0: begin bound_lo = 32'h8000_0000; bound_hi = 32'h7FFF_FFFF; end
               1: begin bound_lo = 32'h0005_0000; bound_hi = 32'hFFFB_0000; end
               2: begin bound_lo = 32'h0001_2345; bound_hi = 32'h0001_2345; end
               default: begin bound_lo = 0; bound_hi = 32'd65536; end
            endcase
            configure(bound_lo, bound_hi, rds_pkg::dist_type'(d), 1'(r));
            queue_item(32'h0, 32'h0);
            queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            queue_item(32'h0000_0001, 32'h4000_0000);
            queue_item(32'h8000_0000, 32'h8000_0000);
            queue_item(32'h7FFF_FFFF, 32'hC000_0000);
            queue_item(32'h0000_0001, 32'h3FFF_FFFF);
            wait_idle();
         end
      end
      for (int ph = 0; ph < 10; ph++) begin
         configure($urandom(), $urandom(), rds_pkg::dist_type'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
         for (int i = 0; i < 50; i++) begin
            if (i == 25 && ph == 3) begin
               while (pending_items.size() > 0) @(negedge clock);
               hold_sender = 1;
               while (req_valid || expected_samples.size() > 0) @(negedge clock);
               hold_sender = 0;
            end
            if ($urandom_range(0, 9) == 0)
               queue_item(32'($urandom_range(0, 15)), $urandom());
            else if ($urandom_range(0, 9) == 0)
               queue_item(32'hFFFF_FFFF - 32'($urandom_range(0, 15)), $urandom());
            else
               queue_item($urandom(), $urandom());
         end
         wait_idle();
      end
      $display("checked %0d results over all four shapes with swapped, equal and extreme bounds",
               checked_count);
      $display("accepted %0d items with random gaps and stalls on both channels", sent_count);
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
